// File: src/g2a_pkg.sv
// ----------------------------------------------------------------------------
// g2a_pkg
// Shared types and constants of the grayscale to character resampler.
// ----------------------------------------------------------------------------
package g2a_pkg;

  localparam int SRC_W        = 9;
  localparam int OUT_W        = 11;
  localparam int COUNT_W      = 5;
  localparam int PAL_W        = 64;
  localparam int ADDR_W       = 16;
  localparam int PIX_W        = 8;
  localparam int CELL_W       = 10;
  localparam int SYM_W        = 8;
  localparam int IDX_W        = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int DIVIDEND_W   = CELL_W + SRC_W;
  localparam int STORE_DEPTH  = 1 << ADDR_W;
  localparam int SRC_REG_MAX  = (1 << SRC_W) - 1;

  localparam int MAX_DIMENSION_DEF = 256;
  localparam int PALETTE_SIZE_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF   = 2;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_WIDTH  = 3'd0,
    CFG_SOURCE_HEIGHT = 3'd1,
    CFG_OUTPUT_WIDTH  = 3'd2,
    CFG_OUTPUT_HEIGHT = 3'd3,
    CFG_SYMBOL_COUNT  = 3'd4,
    CFG_PALETTE_LOW   = 3'd5,
    CFG_PALETTE_HIGH  = 3'd6
  } cfg_index_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ADDR,
    ST_READ,
    ST_MUL,
    ST_EMIT
  } back_state_e;

  typedef struct packed {
    logic              operation;
    logic [ADDR_W-1:0] pixel_address;
    logic [PIX_W-1:0]  pixel_value;
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
  } in_req_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             out_of_range;
  } out_rsp_t;

  typedef struct packed {
    logic [SRC_W-1:0]   source_width;
    logic [SRC_W-1:0]   source_height;
    logic [OUT_W-1:0]   output_width;
    logic [OUT_W-1:0]   output_height;
    logic [COUNT_W-1:0] symbol_count;
    logic [PAL_W-1:0]   palette_low;
    logic [PAL_W-1:0]   palette_high;
  } cfg_t;

  typedef struct packed {
    logic              is_load;
    logic              out_of_range;
    logic [ADDR_W-1:0] pixel_address;
    logic [PIX_W-1:0]  pixel_value;
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
  } queue_entry_t;

endpackage

// File: src/g2a_front.sv
// ----------------------------------------------------------------------------
// g2a_front
// Holds the configuration registers, classifies incoming requests and
// flags cells that fall outside the output grid.
// ----------------------------------------------------------------------------
module g2a_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [g2a_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [g2a_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  g2a_pkg::in_req_t                    in_req_i,
  input  logic                                q_full_i,
  output logic                                q_push_o,
  output g2a_pkg::queue_entry_t               q_entry_o,
  output g2a_pkg::cfg_t                       cfg_o
);
  import g2a_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_SOURCE_WIDTH:  cfg_d.source_width  = cfg_wdata_i[SRC_W-1:0];
        CFG_SOURCE_HEIGHT: cfg_d.source_height = cfg_wdata_i[SRC_W-1:0];
        CFG_OUTPUT_WIDTH:  cfg_d.output_width  = cfg_wdata_i[OUT_W-1:0];
        CFG_OUTPUT_HEIGHT: cfg_d.output_height = cfg_wdata_i[OUT_W-1:0];
        CFG_SYMBOL_COUNT:  cfg_d.symbol_count  = cfg_wdata_i[COUNT_W-1:0];
        CFG_PALETTE_LOW:   cfg_d.palette_low   = cfg_wdata_i[PAL_W-1:0];
        CFG_PALETTE_HIGH:  cfg_d.palette_high  = cfg_wdata_i[PAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_width  <= SRC_W'(256);
      cfg_q.source_height <= SRC_W'(256);
      cfg_q.output_width  <= OUT_W'(256);
      cfg_q.output_height <= OUT_W'(256);
      cfg_q.symbol_count  <= COUNT_W'(16);
      cfg_q.palette_low   <= '0;
      cfg_q.palette_high  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o      = cfg_q;
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_entry_o.is_load       = (in_req_i.operation == OP_LOAD);
    q_entry_o.out_of_range  = (OUT_W'(in_req_i.cell_x) >= cfg_q.output_width) ||
                              (OUT_W'(in_req_i.cell_y) >= cfg_q.output_height);
    q_entry_o.pixel_address = in_req_i.pixel_address;
    q_entry_o.pixel_value   = in_req_i.pixel_value;
    q_entry_o.cell_x        = in_req_i.cell_x;
    q_entry_o.cell_y        = in_req_i.cell_y;
  end

endmodule

// File: src/g2a_fifo.sv
// ----------------------------------------------------------------------------
// g2a_fifo
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module g2a_fifo #(
  parameter int DEPTH = g2a_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  g2a_pkg::queue_entry_t push_data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output g2a_pkg::queue_entry_t pop_data_o,
  output logic                  empty_o
);
  import g2a_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  queue_entry_t    slot_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (32'(p) == DEPTH - 1) r = '0;
    else                     r = PW'(p + PW'(1));
    return r;
  endfunction

  assign full_o     = (32'(count_q) == DEPTH);
  assign empty_o    = (count_q == '0);
  assign pop_data_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) count_d = CW'(count_q + CW'(1));
    if (!push_i && pop_i) count_d = CW'(count_q - CW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// File: src/g2a_div.sv
// ----------------------------------------------------------------------------
// g2a_div
// Restoring divider, one quotient bit per cycle, for the source coordinate.
// ----------------------------------------------------------------------------
module g2a_div #(
  parameter int QW = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [g2a_pkg::DIVIDEND_W-1:0]    dividend_i,
  input  logic [g2a_pkg::OUT_W-1:0]         divisor_i,
  output logic                              busy_o,
  output logic [QW-1:0]                     quotient_o
);
  import g2a_pkg::*;

  localparam int DSW = OUT_W + QW;
  localparam int CMW = (DIVIDEND_W > DSW) ? DIVIDEND_W : DSW;
  localparam int SCW = $clog2(QW + 1);

  logic                  busy_q, busy_d;
  logic [SCW-1:0]        step_q, step_d;
  logic [DIVIDEND_W-1:0] rem_q, rem_d;
  logic [DSW-1:0]        dsr_q, dsr_d;
  logic [QW-1:0]         quo_q, quo_d;
  logic                  fits;

  assign fits = CMW'(rem_q) >= CMW'(dsr_q);

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = SCW'(QW);
      rem_d  = dividend_i;
      dsr_d  = DSW'(divisor_i) << (QW - 1);
      quo_d  = '0;
    end else if (busy_q) begin
      if (fits) rem_d = DIVIDEND_W'(CMW'(rem_q) - CMW'(dsr_q));
      quo_d  = QW'({quo_q, fits});
      dsr_d  = dsr_q >> 1;
      step_d = SCW'(step_q - SCW'(1));
      if (step_q == SCW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// File: src/g2a_back.sv
// ----------------------------------------------------------------------------
// g2a_back
// Carries out queued requests: pixel store writes, coordinate division,
// store read, brightness quantization and palette lookup.
// ----------------------------------------------------------------------------
module g2a_back #(
  parameter int MAX_DIMENSION = g2a_pkg::MAX_DIMENSION_DEF,
  parameter int PALETTE_SIZE  = g2a_pkg::PALETTE_SIZE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  g2a_pkg::cfg_t         cfg_i,
  input  logic                  q_empty_i,
  input  g2a_pkg::queue_entry_t q_head_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output g2a_pkg::out_rsp_t     out_rsp_o
);
  import g2a_pkg::*;

  localparam int WMAX = (MAX_DIMENSION < SRC_REG_MAX) ? MAX_DIMENSION : SRC_REG_MAX;
  localparam int QW   = (WMAX > 1) ? $clog2(WMAX) : 1;
  localparam int PRW  = PIX_W + IDX_W;

  back_state_e            state_q, state_d;
  logic                   out_valid_q, out_valid_d;
  out_rsp_t               out_rsp_q, out_rsp_d;
  logic [QW-1:0]          sx_q, sx_d, sy_q, sy_d;
  logic [ADDR_W-1:0]      addr_q, addr_d;
  logic [PRW-1:0]         prod_q, prod_d;
  logic [PIX_W-1:0]       rdata_q;
  logic [PIX_W-1:0]       mem_q [STORE_DEPTH];

  logic [SRC_W-1:0]       w_c, h_c;
  logic [COUNT_W-1:0]     cnt_c;
  logic [IDX_W-1:0]       cnt_m1;
  logic [IDX_W-1:0]       idx;
  logic [2*PAL_W-1:0]     palette;
  logic                   slot_free;
  logic                   div_start;
  logic                   busy_x, busy_y;
  logic [QW-1:0]          quo_x, quo_y;
  logic [DIVIDEND_W-1:0]  dividend_x, dividend_y;
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_addr;
  logic [PRW:0]           q255;

  // clamp configuration to usable ranges
  always_comb begin
    if (cfg_i.source_width == '0)         w_c = SRC_W'(1);
    else if (32'(cfg_i.source_width) > WMAX) w_c = SRC_W'(WMAX);
    else                                  w_c = cfg_i.source_width;
    if (cfg_i.source_height == '0)        h_c = SRC_W'(1);
    else if (32'(cfg_i.source_height) > WMAX) h_c = SRC_W'(WMAX);
    else                                  h_c = cfg_i.source_height;
    if (cfg_i.symbol_count == '0)         cnt_c = COUNT_W'(1);
    else if (32'(cfg_i.symbol_count) > PALETTE_SIZE) cnt_c = COUNT_W'(PALETTE_SIZE);
    else                                  cnt_c = cfg_i.symbol_count;
    cnt_m1 = IDX_W'(cnt_c - COUNT_W'(1));
  end

  assign dividend_x = DIVIDEND_W'(q_head_i.cell_x) * DIVIDEND_W'(w_c);
  assign dividend_y = DIVIDEND_W'(q_head_i.cell_y) * DIVIDEND_W'(h_c);

  g2a_div #(.QW(QW)) u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend_x),
    .divisor_i  (cfg_i.output_width),
    .busy_o     (busy_x),
    .quotient_o (quo_x)
  );

  g2a_div #(.QW(QW)) u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend_y),
    .divisor_i  (cfg_i.output_height),
    .busy_o     (busy_y),
    .quotient_o (quo_y)
  );

  // floor(v / 255) for every value of the 12-bit product
  assign q255    = (PRW+1)'((PRW+1)'(prod_q) + (PRW+1)'(1) + (PRW+1)'(prod_q >> 8));
  assign idx     = IDX_W'(q255 >> 8);
  assign palette = {cfg_i.palette_high, cfg_i.palette_low};

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_rsp_d   = out_rsp_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    addr_d      = addr_q;
    prod_d      = prod_q;
    q_pop_o     = 1'b0;
    div_start   = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = addr_q;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          if (q_head_i.is_load) begin
            mem_we   = 1'b1;
            mem_addr = q_head_i.pixel_address;
            q_pop_o  = 1'b1;
          end else if (q_head_i.out_of_range) begin
            if (slot_free) begin
              out_valid_d            = 1'b1;
              out_rsp_d.symbol       = '0;
              out_rsp_d.out_of_range = 1'b1;
              q_pop_o                = 1'b1;
            end
          end else begin
            div_start = 1'b1;
            q_pop_o   = 1'b1;
            state_d   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (!busy_x && !busy_y) begin
          sx_d    = quo_x;
          sy_d    = quo_y;
          state_d = ST_ADDR;
        end
      end
      ST_ADDR: begin
        addr_d  = ADDR_W'(((2*SRC_W)'(sy_q) * (2*SRC_W)'(w_c)) + (2*SRC_W)'(sx_q));
        state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        prod_d  = PRW'(rdata_q) * PRW'(cnt_m1);
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d            = 1'b1;
          out_rsp_d.symbol       = palette[{idx, 3'b000} +: SYM_W];
          out_rsp_d.out_of_range = 1'b0;
          state_d                = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rsp_q <= out_rsp_d;
    sx_q      <= sx_d;
    sy_q      <= sy_d;
    addr_q    <= addr_d;
    prod_q    <= prod_d;
  end

  // pixel store, single port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= q_head_i.pixel_value;
    rdata_q <= mem_q[mem_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// File: src/gray_to_ascii_resampler.sv
// ----------------------------------------------------------------------------
// gray_to_ascii_resampler
// Nearest neighbour scaler from a stored grayscale image to palette characters.
// ----------------------------------------------------------------------------
// Requests enter on in_valid_i/in_ready_o. A load request writes one pixel
// into the 64K x 8 pixel store and gives no response. A convert request
// names an output cell and gives one response on out_valid_o/out_ready_i:
// the palette character, or zero with out_of_range set for a cell outside
// the output grid.
// Requests pass through a queue, two entries deep by default, to the
// execution side, so the input keeps accepting while a response waits in
// the output register. A load or an out-of-range convert is handled by the
// execution side in its idle state. An in-range convert runs the bit-serial
// coordinate dividers (8 quotient bits at the default dimension limit), then
// address multiply, store read, quantize multiply and palette lookup.
// When the receiver stalls, one response waits in the output register, the
// execution side holds its next response and the queue fills, then
// in_ready_o drops. Reset restores the configuration defaults and empties
// the queue; the pixel store is not cleared and needs no clearing pass.
// Configuration writes on cfg_we_i take effect at the next clock edge.
// ----------------------------------------------------------------------------
module gray_to_ascii_resampler #(
  parameter int MAX_DIMENSION = g2a_pkg::MAX_DIMENSION_DEF,
  parameter int PALETTE_SIZE  = g2a_pkg::PALETTE_SIZE_DEF,
  parameter int QUEUE_DEPTH   = g2a_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [g2a_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [g2a_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  g2a_pkg::in_req_t               in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output g2a_pkg::out_rsp_t              out_rsp_o
);
  import g2a_pkg::*;

  cfg_t         cfg;
  queue_entry_t push_entry, head_entry;
  logic         q_push, q_full, q_pop, q_empty;

  g2a_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (push_entry),
    .cfg_o       (cfg)
  );

  g2a_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_entry),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (head_entry),
    .empty_o     (q_empty)
  );

  g2a_back #(
    .MAX_DIMENSION (MAX_DIMENSION),
    .PALETTE_SIZE  (PALETTE_SIZE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_empty_i   (q_empty),
    .q_head_i    (head_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

// File: bench/gray_to_ascii_resampler_tb.sv
// ----------------------------------------------------------------------------
// gray_to_ascii_resampler_tb
// Self-checking bench for the grayscale to character resampler.
// ----------------------------------------------------------------------------
// A directed table covers the reset state, the grid edges, clamped register
// values and the zero output size. Random phases follow, each with its own
// configuration: an image of up to 128 pixels is preloaded, a larger one as
// needed, and cells are converted while stray loads go anywhere in the store.
// Responses are checked against a local copy of the pixel store and the
// registers, or the table for typed rows. Both handshakes idle at random.
// One phase runs without idling, one holds the output off long enough to
// back up the input, and one pauses the requests until all responses are in.
// ----------------------------------------------------------------------------
module gray_to_ascii_resampler_tb;
  import g2a_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 20;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned BULK_LIMIT     = 128;
  localparam int unsigned FULL_SCALE     = 255;
  localparam int unsigned PHASE_ITEMS    = 55;

  typedef enum logic [1:0] {
    ROW_REQUEST,
    ROW_TYPED,
    ROW_REGISTER
  } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    in_req_t     request;
    out_rsp_t    result;
    cfg_index_e  reg_index;
    logic [63:0] reg_data;
  } stimulus_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_req_t               in_req_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_rsp_t              out_rsp_o;

  logic [SRC_W-1:0]   shadow_src_width    = 9'd256;
  logic [SRC_W-1:0]   shadow_src_height   = 9'd256;
  logic [OUT_W-1:0]   shadow_out_width    = 11'd256;
  logic [OUT_W-1:0]   shadow_out_height   = 11'd256;
  logic [COUNT_W-1:0] shadow_symbol_count = 5'd16;
  logic [PAL_W-1:0]   shadow_palette_low  = '0;
  logic [PAL_W-1:0]   shadow_palette_high = '0;

  logic [PIX_W-1:0] image_copy [STORE_DEPTH];
  bit               pixel_loaded [STORE_DEPTH];
  out_rsp_t         pending_symbols [$];
  stimulus_row_t    directed_rows [$];

  int unsigned error_count = 0;
  int unsigned stall_cycles = 0;
  bit          idling_on = 1'b1;
  bit          hold_output_request = 1'b0;

  gray_to_ascii_resampler DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // nearest neighbour source pixel of an in-range cell
  function automatic logic [ADDR_W-1:0] source_address(logic [CELL_W-1:0] x,
                                                        logic [CELL_W-1:0] y);
    int unsigned w, h, sx, sy;
    w  = clamp_to(shadow_src_width, MAX_DIMENSION_DEF);
    h  = clamp_to(shadow_src_height, MAX_DIMENSION_DEF);
    sx = (32'(x) * w) / 32'(shadow_out_width);
    sy = (32'(y) * h) / 32'(shadow_out_height);
    if (sx >= w) sx = w - 1;
    if (sy >= h) sy = h - 1;
    return ADDR_W'(sy * w + sx);
  endfunction

  function automatic out_rsp_t predict_symbol(in_req_t request);
    out_rsp_t    rsp;
    int unsigned bright, level;
    logic [63:0] bank;
    rsp = '0;
    if (request.cell_x >= shadow_out_width || request.cell_y >= shadow_out_height) begin
      rsp.out_of_range = 1'b1;
    end else begin
      bright = image_copy[source_address(request.cell_x, request.cell_y)];
      level  = (bright * (clamp_to(shadow_symbol_count, PALETTE_SIZE_DEF) - 1)) / FULL_SCALE;
      bank   = (level < 8) ? shadow_palette_low : shadow_palette_high;
      rsp.symbol = bank[8 * (level % 8) +: 8];
    end
    return rsp;
  endfunction

  function automatic in_req_t make_request(logic op, logic [ADDR_W-1:0] addr,
                                           logic [PIX_W-1:0] value,
                                           logic [CELL_W-1:0] x, logic [CELL_W-1:0] y);
    in_req_t request;
    request.operation     = op;
    request.pixel_address = addr;
    request.pixel_value   = value;
    request.cell_x        = x;
    request.cell_y        = y;
    return request;
  endfunction

  function automatic stimulus_row_t request_row(logic op, int unsigned addr,
                                                int unsigned value,
                                                int unsigned x, int unsigned y);
    stimulus_row_t row;
    row.kind      = ROW_REQUEST;
    row.request   = make_request(op, ADDR_W'(addr), PIX_W'(value), CELL_W'(x), CELL_W'(y));
    row.result    = '0;
    row.reg_index = CFG_SOURCE_WIDTH;
    row.reg_data  = '0;
    return row;
  endfunction

  function automatic stimulus_row_t typed_row(int unsigned x, int unsigned y,
                                              logic [SYM_W-1:0] symbol, logic oor);
    stimulus_row_t row;
    row = request_row(OP_CONVERT, 0, 0, x, y);
    row.kind                = ROW_TYPED;
    row.result.symbol       = symbol;
    row.result.out_of_range = oor;
    return row;
  endfunction

  function automatic stimulus_row_t register_row(cfg_index_e idx, logic [63:0] data);
    stimulus_row_t row;
    row = request_row(OP_LOAD, 0, 0, 0, 0);
    row.kind      = ROW_REGISTER;
    row.reg_index = idx;
    row.reg_data  = data;
    return row;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch in %s: got %0h, want %0h", what, got, want);
    error_count++;
  endtask

  function automatic int unsigned idle_gap();
    int unsigned gap;
    gap = 0;
    while (idling_on && $urandom_range(99) < 14) gap++;
    return gap;
  endfunction

  // called at a rising edge, returns at the edge that accepts the request
  task automatic send_request(in_req_t request, bit typed, out_rsp_t typed_rsp);
    int unsigned gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= request;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (request.operation == OP_LOAD) begin
      image_copy[request.pixel_address]   = request.pixel_value;
      pixel_loaded[request.pixel_address] = 1'b1;
    end else begin
      pending_symbols.push_back(typed ? typed_rsp : predict_symbol(request));
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_symbols.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_index_e idx, logic [63:0] data);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SOURCE_WIDTH:  shadow_src_width    = data[SRC_W-1:0];
      CFG_SOURCE_HEIGHT: shadow_src_height   = data[SRC_W-1:0];
      CFG_OUTPUT_WIDTH:  shadow_out_width    = data[OUT_W-1:0];
      CFG_OUTPUT_HEIGHT: shadow_out_height   = data[OUT_W-1:0];
      CFG_SYMBOL_COUNT:  shadow_symbol_count = data[COUNT_W-1:0];
      CFG_PALETTE_LOW:   shadow_palette_low  = data;
      CFG_PALETTE_HIGH:  shadow_palette_high = data;
      default: ;
    endcase
  endtask

  function automatic logic [CELL_W-1:0] pick_cell(logic [OUT_W-1:0] span);
    if (span != 0 && $urandom_range(99) < 85)
      return CELL_W'($urandom_range(span > 1024 ? 1023 : span - 1));
    return CELL_W'($urandom_range(1023));
  endfunction

  task automatic run_phase(logic [SRC_W-1:0] w, logic [SRC_W-1:0] h,
                           logic [OUT_W-1:0] ow, logic [OUT_W-1:0] oh,
                           logic [COUNT_W-1:0] cnt, logic [63:0] pal_lo,
                           logic [63:0] pal_hi, bit hold_midway, bit drain_midway);
    int unsigned      image_pixels, pick;
    logic [CELL_W-1:0] x, y;
    logic [ADDR_W-1:0] target;
    write_register(CFG_SOURCE_WIDTH, 64'(w));
    write_register(CFG_SOURCE_HEIGHT, 64'(h));
    write_register(CFG_OUTPUT_WIDTH, 64'(ow));
    write_register(CFG_OUTPUT_HEIGHT, 64'(oh));
    write_register(CFG_SYMBOL_COUNT, 64'(cnt));
    write_register(CFG_PALETTE_LOW, pal_lo);
    write_register(CFG_PALETTE_HIGH, pal_hi);
    image_pixels = clamp_to(w, MAX_DIMENSION_DEF) * clamp_to(h, MAX_DIMENSION_DEF);
    if (image_pixels <= BULK_LIMIT)
      for (int unsigned a = 0; a < image_pixels; a++)
        send_request(make_request(OP_LOAD, ADDR_W'(a), PIX_W'($urandom),
                                  CELL_W'($urandom), CELL_W'($urandom)), 1'b0, '0);
    for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
      if (hold_midway && i == 5) hold_output_request = 1'b1;
      if (drain_midway && i == PHASE_ITEMS / 2) drain_results();
      pick = $urandom_range(99);
      if (pick < 70) begin
        x = pick_cell(shadow_out_width);
        y = pick_cell(shadow_out_height);
        if (x < shadow_out_width && y < shadow_out_height) begin
          target = source_address(x, y);
          // never read a store entry that was not loaded
          if (!pixel_loaded[target])
            send_request(make_request(OP_LOAD, target, PIX_W'($urandom),
                                      CELL_W'($urandom), CELL_W'($urandom)), 1'b0, '0);
        end
        send_request(make_request(OP_CONVERT, ADDR_W'($urandom), PIX_W'($urandom), x, y),
                     1'b0, '0);
      end else begin
        target = (pick < 88) ? ADDR_W'($urandom_range(image_pixels - 1)) : ADDR_W'($urandom);
        send_request(make_request(OP_LOAD, target, PIX_W'($urandom),
                                  CELL_W'($urandom), CELL_W'($urandom)), 1'b0, '0);
      end
    end
  endtask

  task automatic build_directed_table();
    // reset configuration, palette all zero
    directed_rows.push_back(typed_row(256, 0, 8'h00, 1'b1));
    directed_rows.push_back(typed_row(0, 256, 8'h00, 1'b1));
    directed_rows.push_back(typed_row(1023, 1023, 8'h00, 1'b1));
    directed_rows.push_back(request_row(OP_LOAD, 0, 255, 1023, 1023));
    directed_rows.push_back(typed_row(0, 0, 8'h00, 1'b0));
    directed_rows.push_back(request_row(OP_LOAD, 65535, 128, 0, 0));
    directed_rows.push_back(request_row(OP_CONVERT, 65535, 255, 255, 255));
    directed_rows.push_back(register_row(CFG_PALETTE_LOW, 64'h4746_4544_4342_4120));
    directed_rows.push_back(register_row(CFG_PALETTE_HIGH, 64'h4F4E_4D4C_4B4A_4948));
    directed_rows.push_back(request_row(OP_CONVERT, 0, 0, 0, 0));
    directed_rows.push_back(request_row(OP_CONVERT, 0, 0, 255, 255));
    // single symbol, then clamped counts
    directed_rows.push_back(register_row(CFG_SYMBOL_COUNT, 64'd1));
    directed_rows.push_back(typed_row(0, 0, 8'h20, 1'b0));
    directed_rows.push_back(register_row(CFG_SYMBOL_COUNT, 64'd0));
    directed_rows.push_back(request_row(OP_CONVERT, 0, 0, 255, 255));
    directed_rows.push_back(register_row(CFG_SYMBOL_COUNT, 64'd31));
    directed_rows.push_back(request_row(OP_CONVERT, 0, 0, 0, 0));
    // zero output width, then the widest grid
    directed_rows.push_back(register_row(CFG_OUTPUT_WIDTH, 64'd0));
    directed_rows.push_back(typed_row(0, 0, 8'h00, 1'b1));
    directed_rows.push_back(register_row(CFG_OUTPUT_WIDTH, 64'd2047));
    directed_rows.push_back(request_row(OP_LOAD, 127, 0, 0, 0));
    directed_rows.push_back(request_row(OP_CONVERT, 0, 0, 1023, 0));
    // clamped source size, tall narrow grid
    directed_rows.push_back(register_row(CFG_SOURCE_WIDTH, 64'd0));
    directed_rows.push_back(register_row(CFG_SOURCE_HEIGHT, 64'd511));
    directed_rows.push_back(register_row(CFG_OUTPUT_WIDTH, 64'd1));
    directed_rows.push_back(register_row(CFG_OUTPUT_HEIGHT, 64'd1024));
    directed_rows.push_back(request_row(OP_LOAD, 255, 77, 0, 0));
    directed_rows.push_back(request_row(OP_CONVERT, 0, 0, 0, 1023));
    directed_rows.push_back(typed_row(1, 0, 8'h00, 1'b1));
  endtask

  always @(posedge clk_i) begin
    out_rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_symbols.size() == 0) begin
        report_mismatch("unexpected response", out_rsp_o, 0);
      end else begin
        want = pending_symbols.pop_front();
        if (out_rsp_o.symbol !== want.symbol)
          report_mismatch("symbol", out_rsp_o.symbol, want.symbol);
        if (out_rsp_o.out_of_range !== want.out_of_range)
          report_mismatch("out_of_range", out_rsp_o.out_of_range, want.out_of_range);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("[gray_to_ascii_resampler] ERROR");
      $finish;
    end
  end

  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_output_request) begin
        hold_output_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_ready_i <= !idling_on || ($urandom_range(99) >= 14);
    end
  end

  initial begin
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_SOURCE_WIDTH;
    cfg_wdata_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    build_directed_table();
    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_REGISTER: write_register(directed_rows[i].reg_index, directed_rows[i].reg_data);
        ROW_TYPED:    send_request(directed_rows[i].request, 1'b1, directed_rows[i].result);
        default:      send_request(directed_rows[i].request, 1'b0, '0);
      endcase
    end

    run_phase(9'd8, 9'd6, 11'd20, 11'd13, 5'd10,
              {$urandom, $urandom}, {$urandom, $urandom}, 1'b0, 1'b0);
    idling_on = 1'b0;
    run_phase(9'd12, 9'd10, 11'd5, 11'd7, 5'd16,
              {$urandom, $urandom}, {$urandom, $urandom}, 1'b0, 1'b0);
    idling_on = 1'b1;
    run_phase(9'd0, 9'd1, 11'd1, 11'd1, 5'd2,
              64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b1, 1'b0);
    run_phase(9'd256, 9'd256, 11'd1024, 11'd1024, 5'd31,
              {$urandom, $urandom}, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1);
    run_phase(9'd511, 9'd300, 11'd3, 11'd2047, 5'd0,
              {$urandom, $urandom}, {$urandom, $urandom}, 1'b0, 1'b0);
    run_phase(9'd9, 9'd7, 11'd13, 11'd0, 5'd5,
              {$urandom, $urandom}, {$urandom, $urandom}, 1'b0, 1'b0);
    repeat (2)
      run_phase(SRC_W'($urandom), SRC_W'($urandom), OUT_W'($urandom), OUT_W'($urandom),
                COUNT_W'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                1'b0, 1'b0);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0 && pending_symbols.size() == 0) begin
      $display("[gray_to_ascii_resampler] OK");
    end else begin
      $display("[gray_to_ascii_resampler] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
src/g2a_pkg.sv
src/g2a_front.sv
src/g2a_fifo.sv
src/g2a_div.sv
src/g2a_back.sv
src/gray_to_ascii_resampler.sv
bench/gray_to_ascii_resampler_tb.sv
